### hdl/lzwc_pkg.sv
package lzwc_pkg;

    localparam int BYTE_W           = 8;
    localparam int CODE_W           = 12;
    localparam int MAX_BITS_W       = 4;
    localparam int M_TDATA_W        = 16;
    localparam int FIRST_CODE       = 256;
    localparam int MIN_CODE_BITS    = 9;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam logic [MAX_BITS_W-1:0] MAX_BITS_RESET = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE_SLOT,
        ST_PROBE_DICT,
        ST_MISS,
        ST_FINAL,
        ST_CLEAR
    } lzwc_state_t;

endpackage

### hdl/lzw_byte_compressor.sv
// channel   | ports                              | fields
// s (in)    | s_tvalid s_tready s_tdata s_tlast  | data_byte in tdata, end_of_stream in tlast
// m (out)   | m_tvalid m_tready m_tdata m_tlast  | code in tdata, final_code in tlast
// cfg       | cfg_wr_en cfg_wr_data              | max_bits
// a byte with a prefix held is hashed, then probed by a slot table read and a dictionary
// read, repeated on each collision; a miss emits the prefix code. the first byte of a
// stream only loads the prefix; an end of stream adds the final code.
// synchronous active-low reset, then a clearing pass zeroes all 2^(MAX_CODE_BITS+1)
// slot table entries (8192 by default) with s_tready low.
// a full output register holds the block in its emit states until m_tready.
module lzw_byte_compressor #(
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lzwc_pkg::BYTE_W-1:0]       s_tdata,    // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lzwc_pkg::M_TDATA_W-1:0]    m_tdata,    // [11:0] code, [15:12] zero
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [lzwc_pkg::MAX_BITS_W-1:0]   cfg_wr_data
);
    import lzwc_pkg::*;

    localparam int HASH_W = MAX_CODE_BITS + 1;
    localparam int SLOTS  = 1 << HASH_W;
    localparam int DEPTH  = 1 << MAX_CODE_BITS;
    localparam int KEY_W  = MAX_CODE_BITS + BYTE_W;
    localparam int DENT_W = HASH_W + KEY_W;
    localparam int NC_W   = MAX_CODE_BITS + 1;

    lzwc_state_t state_reg, state_next;

    logic [MAX_CODE_BITS-1:0] prefix_reg, prefix_next;
    logic                     active_reg, active_next;
    logic [NC_W-1:0]          next_code_reg, next_code_next;
    logic [BYTE_W-1:0]        byte_reg, byte_next;
    logic                     last_reg, last_next;
    logic [HASH_W-1:0]        probe_reg, probe_next;
    logic [HASH_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [MAX_BITS_W-1:0]    max_bits_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]        m_code_reg, m_code_next;
    logic                     m_final_reg, m_final_next;

    logic [MAX_CODE_BITS-1:0] slot_mem [SLOTS];
    logic [MAX_CODE_BITS-1:0] slot_rd_reg;
    logic [DENT_W-1:0]        dict_mem [DEPTH];
    logic [DENT_W-1:0]        dict_rd_reg;

    logic                     slot_rd_en, slot_wr_en;
    logic [HASH_W-1:0]        slot_rd_addr;
    logic [HASH_W-1:0]        slot_wr_addr;
    logic [MAX_CODE_BITS-1:0] slot_wr_data;
    logic                     dict_rd_en, dict_wr_en;
    logic [MAX_CODE_BITS-1:0] dict_wr_addr;

    logic                     out_free;
    logic                     code_in_range;
    logic                     entry_live;
    logic                     key_match;
    logic                     room;
    logic [MAX_BITS_W-1:0]    eff_bits;
    logic [KEY_W-1:0]         key;
    logic [HASH_W-1:0]        in_hash;

    assign out_free      = !m_valid_reg || m_tready;
    assign key           = {prefix_reg, byte_reg};
    assign code_in_range = (slot_rd_reg >= MAX_CODE_BITS'(FIRST_CODE))
                         && ({1'b0, slot_rd_reg} < next_code_reg);
    assign entry_live    = dict_rd_reg[DENT_W-1 -: HASH_W] == probe_reg;
    assign key_match     = dict_rd_reg[KEY_W-1:0] == key;
    assign in_hash       = {1'b0, prefix_reg}
                         ^ {s_tdata, {(HASH_W-BYTE_W){1'b0}}}
                         ^ HASH_W'(s_tdata);

    always_comb begin
        if (max_bits_reg < MAX_BITS_W'(MIN_CODE_BITS)) begin
            eff_bits = MAX_BITS_W'(MIN_CODE_BITS);
        end else if (int'(max_bits_reg) > MAX_CODE_BITS) begin
            eff_bits = MAX_BITS_W'(MAX_CODE_BITS);
        end else begin
            eff_bits = max_bits_reg;
        end
    end

    assign room = (next_code_reg >> eff_bits) == '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!active_reg) begin
                        state_next = s_tlast ? ST_FINAL : ST_IDLE;
                    end else begin
                        state_next = ST_PROBE_SLOT;
                    end
                end
            end
            ST_PROBE_SLOT: begin
                state_next = code_in_range ? ST_PROBE_DICT : ST_MISS;
            end
            ST_PROBE_DICT: begin
                if (entry_live && key_match) begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end else if (entry_live) begin
                    state_next = ST_PROBE_SLOT;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        prefix_next    = prefix_reg;
        active_next    = active_reg;
        next_code_next = next_code_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        probe_next     = probe_reg;
        clr_addr_next  = clr_addr_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_code_next    = m_code_reg;
        m_final_next   = m_final_reg;
        slot_rd_en     = 1'b0;
        slot_rd_addr   = probe_reg + 1'b1;
        slot_wr_en     = 1'b0;
        slot_wr_addr   = probe_reg;
        slot_wr_data   = next_code_reg[MAX_CODE_BITS-1:0];
        dict_rd_en     = 1'b0;
        dict_wr_en     = 1'b0;
        dict_wr_addr   = next_code_reg[MAX_CODE_BITS-1:0];
        case (state_reg)
            ST_CLEAR: begin
                slot_wr_en    = 1'b1;
                slot_wr_addr  = clr_addr_reg;
                slot_wr_data  = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    byte_next = s_tdata;
                    last_next = s_tlast;
                    if (!active_reg) begin
                        prefix_next = MAX_CODE_BITS'(s_tdata);
                        active_next = 1'b1;
                    end else begin
                        probe_next   = in_hash;
                        slot_rd_en   = 1'b1;
                        slot_rd_addr = in_hash;
                    end
                end
            end
            ST_PROBE_SLOT: begin
                dict_rd_en = code_in_range;
            end
            ST_PROBE_DICT: begin
                if (entry_live && key_match) begin
                    prefix_next = slot_rd_reg;
                end else if (entry_live) begin
                    probe_next = probe_reg + 1'b1;
                    slot_rd_en = 1'b1;
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = CODE_W'(prefix_reg);
                    m_final_next = 1'b0;
                    prefix_next  = MAX_CODE_BITS'(byte_reg);
                    if (room) begin
                        slot_wr_en     = 1'b1;
                        dict_wr_en     = 1'b1;
                        next_code_next = next_code_reg + 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_code_next    = CODE_W'(prefix_reg);
                    m_final_next   = 1'b1;
                    prefix_next    = '0;
                    active_next    = 1'b0;
                    next_code_next = NC_W'(FIRST_CODE);
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (slot_wr_en) begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_rd_en) begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dict_wr_en) begin
            dict_mem[dict_wr_addr] <= {probe_reg, key};
        end
        if (dict_rd_en) begin
            dict_rd_reg <= dict_mem[slot_rd_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            prefix_reg    <= '0;
            active_reg    <= 1'b0;
            next_code_reg <= NC_W'(FIRST_CODE);
            max_bits_reg  <= MAX_BITS_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            prefix_reg    <= prefix_next;
            active_reg    <= active_next;
            next_code_reg <= next_code_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                max_bits_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        probe_reg   <= probe_next;
        m_code_reg  <= m_code_next;
        m_final_reg <= m_final_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CODE_W){1'b0}}, m_code_reg};
    assign m_tlast  = m_final_reg;

`ifndef SYNTHESIS
    a_next_code_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        next_code_reg >= NC_W'(FIRST_CODE) && next_code_reg <= NC_W'(DEPTH))
        else $error("next code out of bounds");

    a_insert_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MISS && out_free && room)
        |=> next_code_reg == $past(next_code_reg) + 1'b1)
        else $error("insert did not advance next code");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL && out_free)
        |=> (!active_reg && next_code_reg == NC_W'(FIRST_CODE) && m_tvalid && m_tlast))
        else $error("end of stream did not clear the dictionary");
`endif

endmodule
